/* design/cqe_pkg.sv */
`default_nettype none

package cqe_pkg;

    localparam int DATA_W = 32;

    // Operation carried on the slave tuser
    typedef enum logic [1:0] {
        MODE_ENQ  = 2'd0,
        MODE_DEQ  = 2'd1,
        MODE_DISP = 2'd2,
        MODE_PEEK = 2'd3
    } mode_t;

    // Result status carried on the master tuser
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_EMPTY    = 2'd2
    } status_t;

    typedef enum logic {
        S_IDLE,
        S_EMIT
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic accept;   // take the input beat and update the queue
        logic load;     // load the output register with the pending result
        logic step;     // advance the display walk and read the next entry
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic out_free;   // output register empty or being drained
        logic walk_done;  // pending result is the last one of the item
        logic empty;      // queue holds nothing
    } sts_t;

endpackage

`default_nettype wire

/* design/circular_queue_engine.sv */
`default_nettype none

// Channel   Direction  tdata                 tuser          tlast
// s_axis    in         [31:0] push_value     [1:0] mode     -
// m_axis    out        [31:0] data_out       [1:0] status   last
//
// Sequence: enqueue, dequeue and peek accept the item, then load the output
//   register; display accepts, then loads one result per stored entry,
//   each read in turn through the single read port of the slot memory.
// Reset: rst_n clears pointers and marks the queue empty; slot contents
//   are left as they are and are never sent out before being written.
// Stalls: a result waiting in the output register does not block the
//   next input beat; a held m_axis_tready holds the pending result of that
//   next item, and the input stays closed until the output register drains.

module circular_queue_engine #(
    parameter int DEPTH = 8
) (
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // [31:0] push_value
    input  wire logic [1:0]  s_axis_tuser,   // [1:0] mode

    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // [31:0] data_out
    output logic [1:0]       m_axis_tuser,   // [1:0] status
    output logic             m_axis_tlast
);

    cqe_pkg::cmd_t cmd;
    cqe_pkg::sts_t sts;

    logic signed [cqe_pkg::DATA_W-1:0] out_data;

    // Sequence each item: accept, then emit one or more result beats
    cqe_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Pointers, slot memory, pending result and output register
    cqe_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .in_mode    (s_axis_tuser),
        .in_value   ($signed(s_axis_tdata)),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_data   (out_data),
        .out_status (m_axis_tuser),
        .out_last   (m_axis_tlast)
    );

    assign m_axis_tdata = $unsigned(out_data);

    // An accepted beat always closes the input until its last result is loaded
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted while previous item still in progress");

    // An enqueue always leaves a non-empty queue
    a_enq_fills: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready
        && (s_axis_tuser == cqe_pkg::MODE_ENQ) |=> !sts.empty)
        else $error("queue empty after enqueue");

    // Error results carry zero data and close the item
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser != cqe_pkg::ST_OK)
        |-> (m_axis_tdata == '0) && m_axis_tlast)
        else $error("error result with data or without last");

endmodule

`default_nettype wire

/* design/cqe_ram.sv */
`default_nettype none

module cqe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] q_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            q_reg <= mem_reg[raddr];
        end
    end

    assign rdata = q_reg;

endmodule

`default_nettype wire

/* design/cqe_ctrl.sv */
`default_nettype none

module cqe_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire cqe_pkg::sts_t sts,
    output cqe_pkg::cmd_t      cmd
);

    cqe_pkg::state_t state_reg;
    cqe_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cqe_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            cqe_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = cqe_pkg::S_EMIT;
                end
            end
            cqe_pkg::S_EMIT:
            begin
                // hold the result until the output register can take it
                if (sts.out_free)
                begin
                    cmd.load = 1'b1;
                    if (sts.walk_done)
                    begin
                        state_next = cqe_pkg::S_IDLE;
                    end
                    else
                    begin
                        cmd.step = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = cqe_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* design/cqe_dp.sv */
`default_nettype none

module cqe_dp #(
    parameter int DEPTH = 8
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire cqe_pkg::cmd_t                  cmd,
    output cqe_pkg::sts_t                       sts,
    input  wire logic [1:0]                     in_mode,
    input  wire logic signed [cqe_pkg::DATA_W-1:0] in_value,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic signed [cqe_pkg::DATA_W-1:0]   out_data,
    output logic [1:0]                          out_status,
    output logic                                out_last
);

    localparam int AW = $clog2(DEPTH);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

    function automatic logic [AW-1:0] next_idx(input logic [AW-1:0] i);
        return (i == LAST_IDX) ? '0 : i + 1'b1;
    endfunction

    // queue pointers
    logic [AW-1:0] head_reg, head_next;
    logic [AW-1:0] tail_reg, tail_next;
    logic          empty_reg, empty_next;
    logic [AW-1:0] walk_reg, walk_next;

    // pending result
    logic                        res_disp_reg, res_disp_next;
    logic                        res_ram_reg, res_ram_next;
    logic [cqe_pkg::DATA_W-1:0]  res_data_reg, res_data_next;
    cqe_pkg::status_t            res_status_reg, res_status_next;

    // output register
    logic                        out_valid_reg, out_valid_next;
    logic [cqe_pkg::DATA_W-1:0]  out_data_reg, out_data_next;
    cqe_pkg::status_t            out_status_reg, out_status_next;
    logic                        out_last_reg, out_last_next;

    logic                        ram_we;
    logic [AW-1:0]               ram_waddr;
    logic                        ram_re;
    logic [AW-1:0]               ram_raddr;
    logic [cqe_pkg::DATA_W-1:0]  ram_q;
    logic                        full;
    logic                        walk_done;

    cqe_ram #(
        .WIDTH (cqe_pkg::DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata ($unsigned(in_value)),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_q)
    );

    assign full      = !empty_reg && (next_idx(tail_reg) == head_reg);
    assign walk_done = !res_disp_reg || (walk_reg == tail_reg);

    always_comb
    begin
        head_next       = head_reg;
        tail_next       = tail_reg;
        empty_next      = empty_reg;
        walk_next       = walk_reg;
        res_disp_next   = res_disp_reg;
        res_ram_next    = res_ram_reg;
        res_data_next   = res_data_reg;
        res_status_next = res_status_reg;
        ram_we          = 1'b0;
        ram_waddr       = next_idx(tail_reg);
        ram_re          = 1'b0;
        ram_raddr       = head_reg;

        if (cmd.accept)
        begin
            // read the head for every item; enqueue ignores it
            ram_re          = 1'b1;
            walk_next       = head_reg;
            res_disp_next   = 1'b0;
            res_ram_next    = 1'b0;
            res_data_next   = '0;
            res_status_next = cqe_pkg::ST_OK;
            case (cqe_pkg::mode_t'(in_mode))
                cqe_pkg::MODE_ENQ:
                begin
                    if (empty_reg)
                    begin
                        head_next     = '0;
                        tail_next     = '0;
                        empty_next    = 1'b0;
                        ram_we        = 1'b1;
                        ram_waddr     = '0;
                        res_data_next = $unsigned(in_value);
                    end
                    else if (full)
                    begin
                        res_status_next = cqe_pkg::ST_OVERFLOW;
                    end
                    else
                    begin
                        tail_next     = next_idx(tail_reg);
                        ram_we        = 1'b1;
                        res_data_next = $unsigned(in_value);
                    end
                end
                cqe_pkg::MODE_DEQ:
                begin
                    if (empty_reg)
                    begin
                        res_status_next = cqe_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        res_ram_next = 1'b1;
                        if (head_reg == tail_reg)
                        begin
                            empty_next = 1'b1;
                            head_next  = '0;
                            tail_next  = '0;
                        end
                        else
                        begin
                            head_next = next_idx(head_reg);
                        end
                    end
                end
                cqe_pkg::MODE_PEEK:
                begin
                    if (empty_reg)
                    begin
                        res_status_next = cqe_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        res_ram_next = 1'b1;
                    end
                end
                cqe_pkg::MODE_DISP:
                begin
                    if (empty_reg)
                    begin
                        res_status_next = cqe_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        res_ram_next  = 1'b1;
                        res_disp_next = 1'b1;
                    end
                end
                default:
                begin
                    res_status_next = cqe_pkg::ST_OK;
                end
            endcase
        end

        if (cmd.step)
        begin
            walk_next = next_idx(walk_reg);
            ram_re    = 1'b1;
            ram_raddr = next_idx(walk_reg);
        end
    end

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        out_status_next = out_status_reg;
        out_last_next   = out_last_reg;
        if (cmd.load)
        begin
            out_valid_next  = 1'b1;
            out_data_next   = res_ram_reg ? ram_q : res_data_reg;
            out_status_next = res_status_reg;
            out_last_next   = walk_done;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            empty_reg     <= 1'b1;
            walk_reg      <= '0;
            res_disp_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            empty_reg     <= empty_next;
            walk_reg      <= walk_next;
            res_disp_reg  <= res_disp_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_ram_reg    <= res_ram_next;
        res_data_reg   <= res_data_next;
        res_status_reg <= res_status_next;
        out_data_reg   <= out_data_next;
        out_status_reg <= out_status_next;
        out_last_reg   <= out_last_next;
    end

    assign sts.out_free  = !out_valid_reg || out_ready;
    assign sts.walk_done = walk_done;
    assign sts.empty     = empty_reg;

    assign out_valid  = out_valid_reg;
    assign out_data   = $signed(out_data_reg);
    assign out_status = out_status_reg;
    assign out_last   = out_last_reg;

endmodule

`default_nettype wire

/* dv/tb_circular_queue_engine.sv */
`default_nettype none

module tb_circular_queue_engine;

    timeunit 1ns;
    timeprecision 1ps;

    import cqe_pkg::*;

    localparam int DEPTH      = 8;
    localparam int IDX_W      = $clog2(DEPTH);
    localparam int RAND_ITEMS = 400;
    // Receiver holds off completely for this window, counted from reset release
    localparam int HOLD_START = 300;
    localparam int HOLD_LEN   = 250;
    // Drain allowance, scaled with the depth to cover a display walk over every entry
    localparam int DRAIN_CYC  = 2 * DEPTH + 10;
    localparam int CYCLE_CAP  = 200000;

    // One command beat towards the queue
    typedef struct packed {
        mode_t       op;
        logic [31:0] value;
    } queue_cmd_t;

    // One response beat from the queue
    typedef struct packed {
        status_t     status;
        logic [31:0] data;
        logic        is_last;
    } queue_resp_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;

    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;     // [31:0] push_value
    logic [1:0]  s_axis_tuser = '0;     // [1:0] mode

    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;          // [31:0] data_out
    logic [1:0]  m_axis_tuser;          // [1:0] status
    logic        m_axis_tlast;

    circular_queue_engine #(
        .DEPTH (DEPTH)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Commands waiting to be driven, and responses the queue still owes us
    queue_cmd_t  pending_cmds[$];
    queue_resp_t owed_resps[$];

    // Shadow copy of the ring buffer
    logic [31:0]      shadow_slot [DEPTH];
    logic [IDX_W-1:0] shadow_head = '0;
    logic [IDX_W-1:0] shadow_tail = '0;
    logic             shadow_empty = 1'b1;

    int err_cnt      = 0;
    int cmd_beats    = 0;
    int resp_beats   = 0;
    int overflow_cnt = 0;
    int empty_cnt    = 0;
    int full_walks   = 0;
    int cycle_cnt    = 0;

    // ------------------------------------------------------------------
    // Clock and reset: reset held low at the start, released once
    // ------------------------------------------------------------------
    initial
    begin
        forever #4 clk = ~clk;
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Watchdog: give up on a hung or starved run
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_CAP)
        begin
            $display("Timeout after %0d cycles, %0d responses still owed",
                     cycle_cnt, owed_resps.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Prediction: apply one accepted command to the shadow ring and queue
    // up the responses it must produce
    // ------------------------------------------------------------------
    function automatic logic [IDX_W-1:0] ring_next(logic [IDX_W-1:0] idx);
        return (idx == IDX_W'(DEPTH - 1)) ? '0 : idx + 1'b1;
    endfunction

    function automatic void owe(status_t st, logic [31:0] data, logic is_last);
        queue_resp_t r;
        r.status  = st;
        r.data    = data;
        r.is_last = is_last;
        owed_resps.push_back(r);
    endfunction

    function automatic void apply_queue_op(mode_t op, logic [31:0] value);
        logic [IDX_W-1:0] idx;
        logic             at_end;
        int               n;
        case (op)
            MODE_ENQ:
            begin
                if (shadow_empty)
                begin
                    // first value always lands in slot 0
                    shadow_head    = '0;
                    shadow_tail    = '0;
                    shadow_slot[0] = value;
                    shadow_empty   = 1'b0;
                    owe(ST_OK, value, 1'b1);
                end
                else if (ring_next(shadow_tail) == shadow_head)
                begin
                    overflow_cnt++;
                    owe(ST_OVERFLOW, '0, 1'b1);
                end
                else
                begin
                    shadow_tail              = ring_next(shadow_tail);
                    shadow_slot[shadow_tail] = value;
                    owe(ST_OK, value, 1'b1);
                end
            end
            MODE_DEQ:
            begin
                if (shadow_empty)
                begin
                    empty_cnt++;
                    owe(ST_EMPTY, '0, 1'b1);
                end
                else
                begin
                    owe(ST_OK, shadow_slot[shadow_head], 1'b1);
                    if (shadow_head == shadow_tail)
                    begin
                        // last value gone: pointers snap back to the start
                        shadow_empty = 1'b1;
                        shadow_head  = '0;
                        shadow_tail  = '0;
                    end
                    else
                        shadow_head = ring_next(shadow_head);
                end
            end
            MODE_PEEK:
            begin
                if (shadow_empty)
                begin
                    empty_cnt++;
                    owe(ST_EMPTY, '0, 1'b1);
                end
                else
                    owe(ST_OK, shadow_slot[shadow_head], 1'b1);
            end
            default:
            begin
                // display: walk head to tail, flag the tail entry
                if (shadow_empty)
                begin
                    empty_cnt++;
                    owe(ST_EMPTY, '0, 1'b1);
                end
                else
                begin
                    idx = shadow_head;
                    for (n = 0; n < DEPTH; n++)
                    begin
                        at_end = (idx == shadow_tail) || (n == DEPTH - 1);
                        owe(ST_OK, shadow_slot[idx], at_end);
                        if (at_end)
                            break;
                        idx = ring_next(idx);
                    end
                    if (n == DEPTH - 1)
                        full_walks++;
                end
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Driver: bursts of back-to-back beats with random gaps in between
    // ------------------------------------------------------------------
    int burst_left = 0;
    int gap_left   = 0;

    always @(posedge clk)
    begin
        queue_cmd_t c;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            burst_left    <= $urandom_range(1, 20);
            gap_left      <= 0;
        end
        else if (!s_axis_tvalid || s_axis_tready)
        begin
            if (gap_left > 0)
            begin
                gap_left      <= gap_left - 1;
                s_axis_tvalid <= 1'b0;
            end
            else if (pending_cmds.size() > 0)
            begin
                c = pending_cmds.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tuser  <= c.op;
                s_axis_tdata  <= c.value;
                if (burst_left <= 1)
                begin
                    // occasionally a long unbroken stretch, otherwise short bursts
                    burst_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                               : $urandom_range(1, 12);
                    gap_left   <= $urandom_range(0, 6);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Receiver: segments of always-ready, coin-toss and sparse ready, plus
    // one long hold-off so the queue backs up and stalls the input side
    // ------------------------------------------------------------------
    int rx_cycles = 0;
    int seg_left  = 0;
    int seg_kind  = 0;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            rx_cycles     <= 0;
            seg_left      <= 0;
        end
        else
        begin
            rx_cycles <= rx_cycles + 1;
            if (seg_left == 0)
            begin
                seg_left <= $urandom_range(5, 60);
                seg_kind <= $urandom_range(0, 2);
            end
            else
                seg_left <= seg_left - 1;

            if (rx_cycles >= HOLD_START && rx_cycles < HOLD_START + HOLD_LEN)
                m_axis_tready <= 1'b0;
            else
                case (seg_kind)
                    0:       m_axis_tready <= 1'b1;
                    1:       m_axis_tready <= $urandom_range(0, 1);
                    default: m_axis_tready <= (rx_cycles % 4 == 0);
                endcase
        end
    end

    // ------------------------------------------------------------------
    // Monitor: predict on every accepted command, check every response beat
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        queue_resp_t want;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                cmd_beats++;
                apply_queue_op(mode_t'(s_axis_tuser), s_axis_tdata);
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                resp_beats++;
                if (owed_resps.size() == 0)
                begin
                    $error("Unexpected response beat: status %0d data %h last %0b",
                           m_axis_tuser, m_axis_tdata, m_axis_tlast);
                    err_cnt++;
                end
                else
                begin
                    want = owed_resps.pop_front();
                    if (m_axis_tuser !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, m_axis_tuser);
                        err_cnt++;
                    end
                    if (m_axis_tdata !== want.data)
                    begin
                        $error("data_out: expected %h, got %h", want.data, m_axis_tdata);
                        err_cnt++;
                    end
                    if (m_axis_tlast !== want.is_last)
                    begin
                        $error("last: expected %0b, got %0b", want.is_last, m_axis_tlast);
                        err_cnt++;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    task automatic add_cmd(mode_t op, logic [31:0] value);
        queue_cmd_t c;
        c.op    = op;
        c.value = value;
        pending_cmds.push_back(c);
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 11))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        int    phase_left;
        int    bias;
        int    enq_pct;
        int    roll;
        mode_t op;

        // Display, dequeue and peek on an empty queue report empty
        add_cmd(MODE_DISP, 32'hFFFF_FFFF);
        add_cmd(MODE_DEQ,  32'h0000_0000);
        add_cmd(MODE_PEEK, 32'hFFFF_FFFF);
        // Store then remove the only value: pointers return to the start
        add_cmd(MODE_ENQ,  32'h7FFF_FFFF);
        add_cmd(MODE_DEQ,  32'h0000_0000);
        // Fill to the brim with extreme values, then push once too many
        add_cmd(MODE_ENQ,  32'h8000_0000);
        add_cmd(MODE_ENQ,  32'h7FFF_FFFF);
        add_cmd(MODE_ENQ,  32'h0000_0000);
        add_cmd(MODE_ENQ,  32'hFFFF_FFFF);
        add_cmd(MODE_ENQ,  32'hAAAA_AAAA);
        add_cmd(MODE_ENQ,  32'h5555_5555);
        add_cmd(MODE_ENQ,  32'h0000_0001);
        add_cmd(MODE_ENQ,  32'hFFFF_FFFE);
        add_cmd(MODE_ENQ,  32'h1234_5678);
        // Full display walks all slots; peek leaves the head in place
        add_cmd(MODE_DISP, 32'h0000_0000);
        add_cmd(MODE_PEEK, 32'h0000_0000);
        // Free two slots and refill so the tail wraps past the end
        add_cmd(MODE_DEQ,  32'h0000_0000);
        add_cmd(MODE_DEQ,  32'h0000_0000);
        add_cmd(MODE_ENQ,  32'hDEAD_BEEF);
        add_cmd(MODE_ENQ,  32'hC001_D00D);
        add_cmd(MODE_DISP, 32'h0000_0000);

        // Random part: phases leaning towards filling, draining or balance,
        // so occupancy swings between empty and full many times
        phase_left = 0;
        bias       = 0;
        repeat (RAND_ITEMS)
        begin
            if (phase_left == 0)
            begin
                phase_left = $urandom_range(10, 40);
                bias       = $urandom_range(0, 2);
            end
            phase_left--;
            enq_pct = (bias == 0) ? 70 : (bias == 1) ? 25 : 45;
            roll    = $urandom_range(0, 99);
            if (roll < enq_pct)
                op = MODE_ENQ;
            else if (roll < 90)
                op = MODE_DEQ;
            else if (roll < 95)
                op = MODE_DISP;
            else
                op = MODE_PEEK;
            add_cmd(op, pick_value());
        end

        // Hold until every command has gone in and every response is back
        @(posedge rst_n);
        while (pending_cmds.size() > 0 || s_axis_tvalid)
            @(posedge clk);
        while (owed_resps.size() > 0)
            @(posedge clk);
        // Allow any stray beat to show itself
        repeat (DRAIN_CYC) @(posedge clk);

        $display("Ran %0d commands and checked %0d response beats in %0d cycles.",
                 cmd_beats, resp_beats, cycle_cnt);
        $display("Hit %0d overflows, %0d empty reports and %0d full-depth displays.",
                 overflow_cnt, empty_cnt, full_walks);
        if (err_cnt == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

`default_nettype wire

/* sim.f */
design/cqe_pkg.sv
design/cqe_ram.sv
design/cqe_ctrl.sv
design/cqe_dp.sv
design/circular_queue_engine.sv
dv/tb_circular_queue_engine.sv
